// ===== rtl/bxavg_pkg.sv =====
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types and constants for the box-average RGB to hue block.
// ----------------------------------------------------------------------------
package bxavg_pkg;

  localparam int SUM_W = 26;
  localparam int CNT_W = 19;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_HALF   = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [8:0] saturation;
    logic [7:0] brightness;
    logic       box_empty;
  } result_t;

  // Frame totals handed from the front end to the back end.
  typedef struct packed {
    logic [SUM_W-1:0] red_total;
    logic [SUM_W-1:0] green_total;
    logic [SUM_W-1:0] blue_total;
    logic [CNT_W-1:0] pixels;
  } totals_t;

endpackage

// ===== rtl/bxavg_front.sv =====
// ----------------------------------------------------------------------------
// bxavg_front
// Tracks raster position, tests the centered box and accumulates totals.
// ----------------------------------------------------------------------------
module bxavg_front
  import bxavg_pkg::*;
#(
  parameter int COORD_BITS   = 12,
  parameter int MAX_HALF_BOX = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pix_valid,
  input  pixel_t                pix,
  input  logic [COORD_BITS-1:0] frame_width,
  input  logic [COORD_BITS-1:0] frame_height,
  input  logic [8:0]            box_half_size,
  output logic                  tot_valid,
  output totals_t               tot
);

  localparam int PW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] col_r, row_r;
  logic [SUM_W-1:0]      rsum_r, gsum_r, bsum_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [PW-1:0]         w, h, half, cx, cy, colx, rowx;
  logic                  in_x, in_y, hit, last_col, last_row;
  totals_t               cur;

  always_comb begin
    w    = (frame_width  == '0) ? PW'(1) : PW'(frame_width);
    h    = (frame_height == '0) ? PW'(1) : PW'(frame_height);
    half = (PW'(box_half_size) > PW'(MAX_HALF_BOX)) ? PW'(MAX_HALF_BOX)
                                                      : PW'(box_half_size);
    cx   = w >> 1;
    cy   = h >> 1;
    colx = PW'(col_r);
    rowx = PW'(row_r);
    in_x = (colx < w) && (colx + half >= cx) && (colx < cx + half);
    in_y = (rowx < h) && (rowx + half >= cy) && (rowx < cy + half);
    hit  = in_x && in_y;
    last_col = !(colx + PW'(1) < w);
    last_row = !(rowx + PW'(1) < h);
    cur.red_total   = rsum_r + (hit ? SUM_W'(pix.red)   : '0);
    cur.green_total = gsum_r + (hit ? SUM_W'(pix.green) : '0);
    cur.blue_total  = bsum_r + (hit ? SUM_W'(pix.blue)  : '0);
    cur.pixels      = cnt_r + (hit ? CNT_W'(1) : '0);
  end

  assign tot_valid = pix_valid && last_col && last_row;
  assign tot       = cur;

  // Position and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0;
      rsum_r <= '0; gsum_r <= '0; bsum_r <= '0; cnt_r <= '0;
    end else if (pix_valid) begin
      if (!last_col) begin
        col_r <= col_r + 1'b1;
      end else if (!last_row) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= '0;
        row_r <= '0;
      end
      if (last_col && last_row) begin
        rsum_r <= '0; gsum_r <= '0; bsum_r <= '0; cnt_r <= '0;
      end else begin
        rsum_r <= cur.red_total;
        gsum_r <= cur.green_total;
        bsum_r <= cur.blue_total;
        cnt_r  <= cur.pixels;
      end
    end
  end

endmodule

// ===== rtl/bxavg_fifo.sv =====
// ----------------------------------------------------------------------------
// bxavg_fifo
// Two-entry queue of frame totals between front and back ends.
// ----------------------------------------------------------------------------
module bxavg_fifo
  import bxavg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  totals_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output logic    empty,
  output totals_t rd_data
);

  totals_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== rtl/bxavg_back.sv =====
// ----------------------------------------------------------------------------
// bxavg_back
// Averages frame totals with a shared serial divider and converts to HSV.
// ----------------------------------------------------------------------------
module bxavg_back
  import bxavg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    tot_valid,
  input  totals_t tot,
  output logic    tot_take,
  output logic    res_valid,
  output result_t res,
  input  logic    res_take
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVR = 4'd1;
  localparam logic [3:0] S_DIVG = 4'd2;
  localparam logic [3:0] S_DIVB = 4'd3;
  localparam logic [3:0] S_MINX = 4'd4;
  localparam logic [3:0] S_SAT  = 4'd5;
  localparam logic [3:0] S_HUE  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam int DW = SUM_W;

  logic [3:0]       st_r, st_nxt;
  totals_t          t_r;
  logic [7:0]       ar_r, ag_r, ab_r, mx_r, mn_r;
  logic [1:0]       br_r;
  logic             neg_r;
  logic [DW-1:0]    num_r, quo_r;
  logic [DW:0]      rem_r;
  logic [DW-1:0]    den_r;
  logic [4:0]       bit_r;
  result_t          res_r;
  logic [DW:0]      trial;
  logic [DW-1:0]    q;

  assign tot_take  = (st_r == S_IDLE) && tot_valid;
  assign res_valid = (st_r == S_OUT);
  assign res       = res_r;

  // One quotient bit per cycle, restoring division
  always_comb begin
    trial = {rem_r[DW-1:0], num_r[DW-1]};
    q     = quo_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (tot_valid) st_nxt = (tot.pixels == '0) ? S_OUT : S_DIVR;
      S_DIVR, S_DIVG, S_DIVB, S_SAT, S_HUE:
        if (bit_r == 5'd0) st_nxt = st_r + 4'd1;
      S_MINX: st_nxt = S_SAT;
      S_FIN:  st_nxt = S_OUT;
      S_OUT:  if (res_take) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  // Datapath
  always_ff @(posedge clk) begin
    logic [DW-1:0] qn;
    logic [DW:0]   rn;
    logic [8:0]    d;
    logic signed [9:0] diff;
    logic [8:0]    base;
    logic signed [10:0] hv;
    qn = q;
    rn = trial;
    if (trial >= {1'b0, den_r}) begin
      rn = trial - {1'b0, den_r};
      qn = {quo_r[DW-2:0], 1'b1};
    end else begin
      qn = {quo_r[DW-2:0], 1'b0};
    end
    d = 9'd0; diff = '0; base = 9'd0; hv = '0;
    case (st_r)
      S_IDLE: if (tot_valid) begin
        t_r <= tot;
        if (tot.pixels == '0) res_r <= '{9'd0, 9'd0, 8'd0, 1'b1};
        num_r <= tot.red_total; den_r <= DW'(tot.pixels);
        rem_r <= '0; quo_r <= '0; bit_r <= 5'(DW - 1);
      end
      S_DIVR, S_DIVG, S_DIVB, S_SAT, S_HUE: begin
        num_r <= {num_r[DW-2:0], 1'b0};
        rem_r <= rn;
        quo_r <= qn;
        bit_r <= bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          rem_r <= '0; quo_r <= '0; bit_r <= 5'(DW - 1);
          if (st_r == S_DIVR) begin
            ar_r <= qn[7:0]; num_r <= t_r.green_total;
          end else if (st_r == S_DIVG) begin
            ag_r <= qn[7:0]; num_r <= t_r.blue_total;
          end else if (st_r == S_DIVB) begin
            ab_r <= qn[7:0];
          end else if (st_r == S_SAT) begin
            res_r.saturation <= (mx_r == 8'd0) ? 9'd0 : qn[8:0];
            // hue numerator: 60*|diff|, sign kept aside
            d = {1'b0, mx_r} - {1'b0, mn_r};
            if (d == 9'd0) d = 9'd1;
            den_r <= DW'(d);
            if (br_r == 2'd0) diff = $signed({2'b0, ag_r}) - $signed({2'b0, ab_r});
            else if (br_r == 2'd1) diff = $signed({2'b0, ab_r}) - $signed({2'b0, ar_r});
            else diff = $signed({2'b0, ar_r}) - $signed({2'b0, ag_r});
            neg_r <= diff[9];
            num_r <= DW'(14'd60 * 14'(diff[9] ? -diff : diff));
          end else begin
            base = (br_r == 2'd0) ? 9'd0 : (br_r == 2'd1) ? 9'd120 : 9'd240;
            hv = $signed({2'b0, base})
                 + (neg_r ? -$signed({2'b0, qn[8:0]}) : $signed({2'b0, qn[8:0]}));
            if (hv < 0) hv = hv + 11'sd360;
            if (hv >= 11'sd360) hv = hv - 11'sd360;
            res_r.hue <= hv[8:0];
          end
        end
      end
      S_MINX: begin
        mx_r <= (ar_r >= ag_r && ar_r >= ab_r) ? ar_r : (ag_r >= ab_r) ? ag_r : ab_r;
        mn_r <= (ar_r <= ag_r && ar_r <= ab_r) ? ar_r : (ag_r <= ab_r) ? ag_r : ab_r;
        br_r <= (ar_r >= ag_r && ar_r >= ab_r) ? 2'd0 : (ag_r >= ab_r) ? 2'd1 : 2'd2;
        num_r <= DW'({(ar_r >= ag_r && ar_r >= ab_r) ? (ar_r - ((ar_r <= ag_r && ar_r <= ab_r) ? ar_r : (ag_r <= ab_r) ? ag_r : ab_r))
                 : (ag_r >= ab_r) ? (ag_r - ((ar_r <= ag_r && ar_r <= ab_r) ? ar_r : (ag_r <= ab_r) ? ag_r : ab_r))
                 : (ab_r - ((ar_r <= ag_r && ar_r <= ab_r) ? ar_r : (ag_r <= ab_r) ? ag_r : ab_r)), 8'd0});
        den_r <= DW'((ar_r >= ag_r && ar_r >= ab_r) ? ar_r : (ag_r >= ab_r) ? ag_r : ab_r);
        if (ar_r == 8'd0 && ag_r == 8'd0 && ab_r == 8'd0) den_r <= DW'(1);
      end
      S_FIN: begin
        res_r.brightness <= mx_r;
        res_r.box_empty  <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/box_average_rgb_to_hue_top.sv =====
// ----------------------------------------------------------------------------
// box_average_rgb_to_hue_top
// Box-average of a raster frame, reported as integer hue/saturation/value.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock with no stall except when the totals queue
// is full; each pixel's position comes from internal row and column counters.
// On a frame's last pixel the box totals move into a two-entry queue; the
// back end then runs one serial divider (one quotient bit per cycle, reused
// for three averages, saturation and hue) and offers one result. A frame of
// fewer than about 135 pixels can back the queue up.
module box_average_rgb_to_hue_top
  import bxavg_pkg::*;
#(
  parameter int MAX_HALF_BOX = 256,
  parameter int COORD_BITS   = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  pixel_t     in_data,
  output logic       out_empty,
  input  logic       out_pop,
  output result_t    out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  logic [COORD_BITS-1:0] width_r, height_r;
  logic [8:0]            half_r;
  logic                  px_xfer, tot_valid, q_full, q_empty, take;
  totals_t               tot, q_data;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign px_xfer   = in_push && !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= COORD_BITS'(640); height_r <= COORD_BITS'(480); half_r <= 9'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_HALF:   half_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  bxavg_front #(.COORD_BITS(COORD_BITS), .MAX_HALF_BOX(MAX_HALF_BOX)) u_front (
    .clk, .rst_n, .pix_valid(px_xfer), .pix(in_data),
    .frame_width(width_r), .frame_height(height_r), .box_half_size(half_r),
    .tot_valid, .tot
  );

  bxavg_fifo u_fifo (
    .clk, .rst_n, .wr_en(tot_valid), .wr_data(tot), .full(q_full),
    .rd_en(take), .empty(q_empty), .rd_data(q_data)
  );

  logic res_valid;
  bxavg_back u_back (
    .clk, .rst_n, .tot_valid(!q_empty), .tot(q_data), .tot_take(take),
    .res_valid, .res(out_data), .res_take(out_pop)
  );
  assign out_empty = !res_valid;

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !tot_valid || !px_xfer) else $error("totals dropped");
  a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !q_empty) else $error("read of empty queue");
  a_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty) else $error("result lost");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for box_average_rgb_to_hue_top.
// ----------------------------------------------------------------------------
// Pixels stream in through the push/full queue side. A local frame tracker
// keeps its own row/column counters and box totals and predicts the HSV
// summary of each frame. Results drained through the empty/pop side are
// compared field by field against those predictions in order. A short
// directed table covers the corner cases first: empty box, pure and grey
// colors, negative hue wrap, zero frame size and an oversized box. Partial
// frames at the size extremes come next, cut short by a register change.
// Random phases follow, with small frames, partial frames before a register
// change, and random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
  import bxavg_pkg::*;

  localparam int MAX_HALF  = 256;
  localparam int RAND_PIX  = 1040;
  localparam int EDGE_PIX  = 200;
  localparam int SETTLE    = 200;
  localparam int IDLE_LIMIT = 20000;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [11:0] val;
    pixel_t      pix;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  pixel_t      in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  result_t     out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [11:0] cfg_data = '0;

  // frame tracker state
  logic [11:0] trk_width;
  logic [11:0] trk_height;
  logic [8:0]  trk_half;
  int          trk_col;
  int          trk_row;
  longint      trk_red;
  longint      trk_green;
  longint      trk_blue;
  int          trk_pixels;

  result_t     pending_hsv[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          pop_gap = 0;
  bit          pop_steady = 1'b0;

  box_average_rgb_to_hue_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // box membership along one axis, box clipped to the frame
  function automatic bit axis_hit(int pos, int size, int half);
    int centre;
    centre = size / 2;
    if (pos >= size) return 1'b0;
    return (pos + half >= centre) && (pos < centre + half);
  endfunction

  // averaged color to integer hue/saturation/value
  function automatic result_t box_hsv();
    result_t res;
    int ar, ag, ab, vmax, vmin, delta, hue, sat;
    res = '0;
    if (trk_pixels == 0) begin
      res.box_empty = 1'b1;
      return res;
    end
    ar = int'(trk_red / trk_pixels);
    ag = int'(trk_green / trk_pixels);
    ab = int'(trk_blue / trk_pixels);
    vmax = ar; vmin = ar;
    if (ag > vmax) vmax = ag;
    if (ab > vmax) vmax = ab;
    if (ag < vmin) vmin = ag;
    if (ab < vmin) vmin = ab;
    delta = vmax - vmin;
    sat = (vmax != 0) ? (256 * delta) / vmax : 0;
    if (delta == 0) delta = 1;
    if (ar == vmax) hue = (60 * (ag - ab)) / delta;
    else if (ag == vmax) hue = 120 + (60 * (ab - ar)) / delta;
    else hue = 240 + (60 * (ar - ag)) / delta;
    if (hue < 0) hue += 360;
    if (hue >= 360) hue -= 360;
    res.hue = hue[8:0];
    res.saturation = sat[8:0];
    res.brightness = vmax[7:0];
    return res;
  endfunction

  // advance the tracker by one pixel; returns 1 with the summary at frame end
  function automatic bit predict_pixel(pixel_t p, output result_t res);
    int w, h, half;
    w = (trk_width == 0) ? 1 : int'(trk_width);
    h = (trk_height == 0) ? 1 : int'(trk_height);
    half = (trk_half > MAX_HALF) ? MAX_HALF : int'(trk_half);
    res = '0;
    if (axis_hit(trk_row, h, half) && axis_hit(trk_col, w, half)) begin
      trk_red += p.red;
      trk_green += p.green;
      trk_blue += p.blue;
      trk_pixels++;
    end
    if (trk_col + 1 < w) begin
      trk_col++;
      return 1'b0;
    end
    if (trk_row + 1 < h) begin
      trk_col = 0;
      trk_row++;
      return 1'b0;
    end
    res = box_hsv();
    trk_col = 0; trk_row = 0;
    trk_red = 0; trk_green = 0; trk_blue = 0;
    trk_pixels = 0;
    return 1'b1;
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p = pixel_t'(24'($urandom));
    if (mode == 0) begin
      p.green = p.red;
      p.blue = p.red;
    end else if (mode == 1) begin
      p.red = {8{$urandom_range(0, 1) == 1}};
      p.green = {8{$urandom_range(0, 1) == 1}};
      p.blue = {8{$urandom_range(0, 1) == 1}};
    end
    return p;
  endfunction

  // pixel transfer; typed rows override the tracker's expectation
  task automatic send_pixel(pixel_t p, int gap, bit typed, result_t want, output bit done);
    result_t res;
    repeat (gap) begin
      @(negedge clk) in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_full);
    done = predict_pixel(p, res);
    if (done) pending_hsv.push_back(typed ? want : res);
  endtask

  // register write, only once the block has drained
  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    @(negedge clk) in_push <= 1'b0;
    wait (pending_hsv.size() == 0);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH:  trk_width = val;
      CFG_HEIGHT: trk_height = val;
      CFG_HALF:   trk_half = val[8:0];
      default: ;
    endcase
  endtask

  function automatic logic [11:0] rand_size();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 12'd0;
    if (pick < 3) return 12'($urandom_range(10, 40));
    return 12'($urandom_range(1, 9));
  endfunction

  function automatic logic [11:0] rand_half();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 12'd256;
    if (pick == 1) return 12'($urandom_range(257, 511));
    if (pick == 2) return 12'($urandom);
    return 12'($urandom_range(0, 6));
  endfunction

  // result side: random pop stalls, with steady stretches
  always @(negedge clk) begin
    if (pop_steady || pop_gap == 0) begin
      out_pop <= 1'b1;
      if (!pop_steady) pop_gap = short_gap();
    end else begin
      out_pop <= 1'b0;
      pop_gap--;
    end
  end

  // compare each popped result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_hsv.size() == 0) begin
        $error("unexpected result hue=%0d sat=%0d bri=%0d empty=%0d",
               out_data.hue, out_data.saturation, out_data.brightness,
               out_data.box_empty);
        errors++;
      end else begin
        want = pending_hsv.pop_front();
        if (out_data.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, out_data.hue);
          errors++;
        end
        if (out_data.saturation !== want.saturation) begin
          $error("saturation: expected %0d, got %0d", want.saturation,
                 out_data.saturation);
          errors++;
        end
        if (out_data.brightness !== want.brightness) begin
          $error("brightness: expected %0d, got %0d", want.brightness,
                 out_data.brightness);
          errors++;
        end
        if (out_data.box_empty !== want.box_empty) begin
          $error("box_empty: expected %0d, got %0d", want.box_empty,
                 out_data.box_empty);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** box_average_rgb_to_hue_top: FAILED **");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  function automatic dir_row_t cfg_row(logic [1:0] idx, int val);
    dir_row_t r;
    r = '{ROW_CFG, idx, 12'(val), '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t pix_row(int rd, int gr, int bl, bit typed,
                                        int hue, int sat, int bri, bit emp);
    dir_row_t r;
    r = '{ROW_PIX, CFG_WIDTH, '0, pixel_t'({8'(rd), 8'(gr), 8'(bl)}), typed,
          result_t'({9'(hue), 9'(sat), 8'(bri), emp})};
    return r;
  endfunction

  initial begin
    result_t none;
    bit done;
    int sent, goal, count, frames, limit;
    none = '0;
    trk_width = 12'd640; trk_height = 12'd480; trk_half = 9'd50;
    trk_col = 0; trk_row = 0;
    trk_red = 0; trk_green = 0; trk_blue = 0; trk_pixels = 0;

    // single-pixel frames make every row its own frame
    dir_rows.push_back(cfg_row(CFG_WIDTH, 1));
    dir_rows.push_back(cfg_row(CFG_HEIGHT, 1));
    dir_rows.push_back(cfg_row(CFG_HALF, 0));
    dir_rows.push_back(pix_row(255, 255, 255, 1, 0, 0, 0, 1));   // empty box
    dir_rows.push_back(cfg_row(CFG_HALF, 1));
    dir_rows.push_back(pix_row(255, 0, 0, 1, 0, 256, 255, 0));
    dir_rows.push_back(pix_row(0, 255, 0, 1, 120, 256, 255, 0));
    dir_rows.push_back(pix_row(0, 0, 255, 1, 240, 256, 255, 0));
    dir_rows.push_back(pix_row(255, 255, 255, 1, 0, 0, 255, 0)); // grey
    dir_rows.push_back(pix_row(0, 0, 0, 1, 0, 0, 0, 0));         // black
    dir_rows.push_back(pix_row(255, 0, 255, 1, 300, 256, 255, 0)); // hue wrap
    // zero frame size acts as one
    dir_rows.push_back(cfg_row(CFG_WIDTH, 0));
    dir_rows.push_back(cfg_row(CFG_HEIGHT, 0));
    dir_rows.push_back(pix_row(1, 2, 3, 1, 210, 170, 3, 0));
    // oversized box saturates
    dir_rows.push_back(cfg_row(CFG_HALF, 511));
    dir_rows.push_back(pix_row(200, 100, 50, 0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(CFG_WIDTH, 4095));
    dir_rows.push_back(cfg_row(CFG_WIDTH, 2));
    dir_rows.push_back(cfg_row(CFG_HEIGHT, 2));
    dir_rows.push_back(pix_row(10, 200, 30, 0, 0, 0, 0, 0));
    dir_rows.push_back(pix_row(90, 20, 240, 0, 0, 0, 0, 0));
    dir_rows.push_back(pix_row(0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(pix_row(255, 128, 64, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      else
        send_pixel(dir_rows[i].pix, short_gap(), dir_rows[i].typed,
                   dir_rows[i].want, done);
    end

    // partial frames at the size extremes, cut short by a size change
    write_reg(CFG_HALF, 12'd256);
    write_reg(CFG_HEIGHT, 12'd1);
    write_reg(CFG_WIDTH, 12'd4095);
    repeat (EDGE_PIX) send_pixel(rand_pixel(), 0, 1'b0, none, done);
    write_reg(CFG_WIDTH, 12'd1);
    write_reg(CFG_HEIGHT, 12'd4095);
    repeat (EDGE_PIX) send_pixel(rand_pixel(), $urandom_range(0, 1), 1'b0, none, done);

    // random phases: reconfigure, then whole or partial frames
    sent = 0;
    while (sent < RAND_PIX) begin
      if ($urandom_range(0, 2) != 0) write_reg(CFG_WIDTH, rand_size());
      if ($urandom_range(0, 2) != 0) write_reg(CFG_HEIGHT, rand_size());
      if ($urandom_range(0, 2) != 0) write_reg(CFG_HALF, rand_half());
      pop_steady = ($urandom_range(0, 3) == 0);
      goal = $urandom_range(1, 4);
      limit = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : RAND_PIX - sent;
      frames = 0;
      count = 0;
      while (frames < goal && count < limit) begin
        send_pixel(rand_pixel(), pop_steady ? 0 : short_gap(), 1'b0, none, done);
        frames += done;
        count++;
      end
      sent += count;
    end
    @(negedge clk) in_push <= 1'b0;

    wait (pending_hsv.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("** box_average_rgb_to_hue_top: PASSED **");
    else
      $display("** box_average_rgb_to_hue_top: FAILED **");
    $finish;
  end

endmodule
